FILE: rtl/mcp_pkg.sv
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants for the map capacity planner.
// ----------------------------------------------------------------------------
package mcp_pkg;

    localparam int SIZE_BITS_DEF = 64;
    localparam int FIELD_W       = 64;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_ON_DEMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DENSE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_BYTES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSE_STEP      = 2'd3;

    typedef struct packed {
        logic load;
        logic setup;
        logic dbl;
        logic div;
        logic fix1;
        logic fix2;
        logic fix3;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic grow;
        logic sparse;
        logic div_last;
    } t_dp_stat;

endpackage

FILE: rtl/mcp_in_if.sv
// ----------------------------------------------------------------------------
// mcp_in_if
// Request channel: current size, high-water mark and allocation mode.
// ----------------------------------------------------------------------------
interface mcp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] current_size;
    logic [63:0] high_water;
    logic        on_demand;

    modport source (output valid, output current_size, output high_water,
                    output on_demand, input ready);
    modport sink   (input valid, input current_size, input high_water,
                    input on_demand, output ready);
endinterface

FILE: rtl/mcp_out_if.sv
// ----------------------------------------------------------------------------
// mcp_out_if
// Result channel: planned size and policy check flag.
// ----------------------------------------------------------------------------
interface mcp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] planned_size;
    logic        policy_invalid;

    modport source (output valid, output planned_size, output policy_invalid,
                    input ready);
    modport sink   (input valid, input planned_size, input policy_invalid,
                    output ready);
endinterface

FILE: rtl/map_capacity_planner.sv
// ----------------------------------------------------------------------------
// map_capacity_planner
// Plans a memory map size from the present size, the high-water mark and
// the allocation mode, with floors, a ceiling and saturating growth.
//
// Channels: i_in carries one request transaction (current_size, high_water,
// on_demand); o_out carries one result transaction (planned_size,
// policy_invalid) per request. Both use valid/ready.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write floor_on_demand (0),
// floor_dense (1), ceiling_bytes (2) and dense_step (3), one per write; write
// only while no request is in flight.
// Sequence after accept: setup, then the result when the size does not grow;
// in on-demand mode a doubling loop while the size still grows; in dense mode
// the one-bit-per-cycle remainder unit over all SIZE_BITS bits, then the
// closing steps fix1, fix2 and fix3. No request is taken while one is in
// flight; the next is taken in the cycle after the result is loaded.
// Reset clears the configuration registers to zero and empties the output.
// A stalled receiver holds the result in the output register; a finished
// request waits until that register frees.
// ----------------------------------------------------------------------------
module map_capacity_planner #(
    parameter int SIZE_BITS = mcp_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mcp_in_if.sink                        i_in,
    mcp_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [mcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mcp_pkg::FIELD_W-1:0]   i_cfg_data
);
    import mcp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mcp_datapath #(
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_current_size   (i_in.current_size),
        .i_high_water     (i_in.high_water),
        .i_on_demand      (i_in.on_demand),
        .o_planned_size   (o_out.planned_size),
        .o_policy_invalid (o_out.policy_invalid)
    );

endmodule

FILE: rtl/mcp_datapath.sv
// ----------------------------------------------------------------------------
// mcp_datapath
// Configuration registers, size/requirement registers, doubling step,
// bit-serial remainder unit for the dense step count, and result register.
// ----------------------------------------------------------------------------
module mcp_datapath #(
    parameter int SIZE_BITS = mcp_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcp_pkg::t_dp_cmd              i_cmd,
    output mcp_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic [mcp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mcp_pkg::FIELD_W-1:0]   i_cfg_data,
    input  logic [mcp_pkg::FIELD_W-1:0]   i_current_size,
    input  logic [mcp_pkg::FIELD_W-1:0]   i_high_water,
    input  logic                          i_on_demand,
    output logic [mcp_pkg::FIELD_W-1:0]   o_planned_size,
    output logic                          o_policy_invalid
);
    import mcp_pkg::*;

    localparam int CNT_W = $clog2(SIZE_BITS);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    logic [SIZE_BITS-1:0] r_floor_od, r_floor_dn, r_ceil, r_step;
    logic [SIZE_BITS-1:0] r_size, r_req, r_gap, r_rem, r_dvd, r_out_size;
    logic                 r_sparse, r_inv, r_odd, r_out_inv;
    logic [CNT_W-1:0]     r_cnt;

    logic [SIZE_BITS-1:0] cur_m, hw_m, floor_v, start_v, reserve, req_v;
    logic [SIZE_BITS-1:0] lim, dbl_v, rem_new, add_v, fin_v;
    logic [SIZE_BITS:0]   req_sum, dbl_sum, rem_sh, add_sum, fin_sum;
    logic                 rem_ge, inv_v;

    always_comb begin
        cur_m   = i_current_size[SIZE_BITS-1:0];
        hw_m    = i_high_water[SIZE_BITS-1:0];
        floor_v = i_on_demand ? r_floor_od : r_floor_dn;
        start_v = (cur_m > floor_v) ? cur_m : floor_v;
        reserve = i_on_demand ? hw_m : r_step;
        req_sum = {1'b0, hw_m} + {1'b0, reserve};
        req_v   = req_sum[SIZE_BITS] ? SIZE_MAX : req_sum[SIZE_BITS-1:0];
        inv_v   = (r_ceil != '0) && ((r_floor_od > r_ceil) || (r_floor_dn > r_ceil));

        lim     = (r_req < r_ceil) ? r_req : r_ceil;

        dbl_sum = {1'b0, r_size} + {1'b0, r_size};
        dbl_v   = dbl_sum[SIZE_BITS] ? SIZE_MAX : dbl_sum[SIZE_BITS-1:0];
        dbl_v   = (dbl_v < r_ceil) ? dbl_v : r_ceil;

        rem_sh  = {r_rem, r_dvd[SIZE_BITS-1]};
        rem_ge  = rem_sh >= {1'b0, r_step};
        rem_new = rem_ge ? SIZE_BITS'(rem_sh - {1'b0, r_step}) : rem_sh[SIZE_BITS-1:0];

        add_sum = {1'b0, r_gap} + {1'b0, r_step};
        add_v   = add_sum[SIZE_BITS] ? SIZE_MAX : add_sum[SIZE_BITS-1:0];

        fin_sum = {1'b0, r_size} + {1'b0, r_gap};
        fin_v   = fin_sum[SIZE_BITS] ? SIZE_MAX : fin_sum[SIZE_BITS-1:0];
        fin_v   = (fin_v < r_ceil) ? fin_v : r_ceil;

        o_stat.grow     = (r_size < r_req) && (r_size < r_ceil) &&
                          (r_sparse ? (r_size != '0) : (r_step != '0));
        o_stat.sparse   = r_sparse;
        o_stat.div_last = (r_cnt == CNT_W'(SIZE_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_od <= '0;
            r_floor_dn <= '0;
            r_ceil     <= '0;
            r_step     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLOOR_ON_DEMAND: r_floor_od <= i_cfg_data[SIZE_BITS-1:0];
                CFG_FLOOR_DENSE:     r_floor_dn <= i_cfg_data[SIZE_BITS-1:0];
                CFG_CEILING_BYTES:   r_ceil     <= i_cfg_data[SIZE_BITS-1:0];
                CFG_DENSE_STEP:      r_step     <= i_cfg_data[SIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size   <= start_v;
            r_req    <= req_v;
            r_sparse <= i_on_demand;
            r_inv    <= inv_v;
        end
        if (i_cmd.setup) begin
            r_gap <= lim - r_size;
            r_dvd <= lim - r_size;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.dbl) begin
            r_size <= dbl_v;
        end
        if (i_cmd.div) begin
            r_rem <= rem_new;
            r_dvd <= {r_dvd[SIZE_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.fix1) begin
            r_gap <= r_gap - r_rem;
            r_odd <= (r_rem != '0);
        end
        if (i_cmd.fix2) begin
            r_gap <= r_odd ? add_v : r_gap;
        end
        if (i_cmd.fix3) begin
            r_size <= fin_v;
        end
        if (i_cmd.load_out) begin
            r_out_size <= r_size;
            r_out_inv  <= r_inv;
        end
    end

    assign o_planned_size   = FIELD_W'(r_out_size);
    assign o_policy_invalid = r_out_inv;

endmodule

FILE: rtl/mcp_ctrl.sv
// ----------------------------------------------------------------------------
// mcp_ctrl
// Sequencer: accepts a request, steps the doubling loop or the remainder
// unit and closing adds, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mcp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mcp_pkg::t_dp_stat  i_stat,
    output mcp_pkg::t_dp_cmd   o_cmd
);
    import mcp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_DOUBLE = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_FIX1   = 8'b0001_0000,
        S_FIX2   = 8'b0010_0000,
        S_FIX3   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (!i_stat.grow) begin
                    n_state = S_DONE;
                end else if (i_stat.sparse) begin
                    n_state = S_DOUBLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DOUBLE: begin
                if (i_stat.grow) begin
                    o_cmd.dbl = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIX1;
                end
            end
            S_FIX1: begin
                o_cmd.fix1 = 1'b1;
                n_state    = S_FIX2;
            end
            S_FIX2: begin
                o_cmd.fix2 = 1'b1;
                n_state    = S_FIX3;
            end
            S_FIX3: begin
                o_cmd.fix3 = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: bench/map_capacity_planner_tb.sv
// ----------------------------------------------------------------------------
// map_capacity_planner_tb
// Self-checking bench for the map capacity planner. The bench predicts each
// planned size and policy flag from its own copy of the registers. A
// valid/ready driver sends the sizing requests from a queue. A monitor
// compares every result with the oldest prediction. Outside steady phases both
// sides insert random gaps. The register settings change only between phases,
// while the block is idle. Phases go from directed corner cases to randomized settings.
// ----------------------------------------------------------------------------
module map_capacity_planner_tb;
    import mcp_pkg::*;

    localparam logic [63:0] SIZE_MAX       = '1;
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_PHASES  = 14;
    localparam int          PHASE_ITEMS    = 74;

    typedef struct packed {
        logic [63:0] current_size;
        logic [63:0] high_water;
        logic        on_demand;
    } t_size_req;

    typedef struct packed {
        t_size_req req;
        logic      drain;
    } t_pending_req;

    typedef struct packed {
        logic [63:0] planned_size;
        logic        policy_invalid;
    } t_plan;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [FIELD_W-1:0] cfg_data;

    mcp_in_if  in_ch ();
    mcp_out_if out_ch ();

    map_capacity_planner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    logic [63:0]  floor_od_r;
    logic [63:0]  floor_dense_r;
    logic [63:0]  ceiling_r;
    logic [63:0]  step_r;

    t_pending_req req_q[$];
    t_plan        plan_q[$];
    t_plan        plan_got;
    t_plan        plan_want;

    bit  steady;
    int  send_gap;
    int  recv_stall;
    int  idle_cycles;
    int  errors;
    int  total_pushed;
    int  results_seen;
    int  n_on_demand;
    int  n_dense;
    int  n_flagged;
    int  n_saturated;
    int  n_phases;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[64] ? SIZE_MAX : sum[63:0];
    endfunction

    function automatic logic [63:0] min_u64(logic [63:0] a, logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_plan plan_capacity(t_size_req r);
        logic [63:0] floor_v;
        logic [63:0] size;
        logic [63:0] required;
        logic [63:0] lim;
        logic [63:0] gap;
        logic [63:0] add;
        t_plan       p;
        floor_v  = r.on_demand ? floor_od_r : floor_dense_r;
        size     = (r.current_size > floor_v) ? r.current_size : floor_v;
        required = sat_add(r.high_water, r.on_demand ? r.high_water : step_r);
        p.policy_invalid = (ceiling_r != 0) &&
                           (floor_od_r > ceiling_r || floor_dense_r > ceiling_r);
        if (r.on_demand) begin
            while (size < required && size < ceiling_r && size != 0) begin
                size = min_u64(sat_add(size, size), ceiling_r);
            end
        end else if (size < required && size < ceiling_r && step_r != 0) begin
            lim = min_u64(required, ceiling_r);
            gap = lim - size;
            add = (gap / step_r) * step_r;
            if (gap % step_r != 0) begin
                add = sat_add(add, step_r);
            end
            size = min_u64(sat_add(size, add), ceiling_r);
        end
        p.planned_size = size;
        return p;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_val();
        logic [63:0] v;
        int          k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = SIZE_MAX;
            2: v = 64'd1 << k;
            3: v = (64'd1 << k) - 64'd1;
            4: v = 64'($urandom_range(0, 4096));
            5: v = rnd64() >> k;
            default: v = rnd64();
        endcase
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 80);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: present pending requests, hold them until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                plan_want = plan_capacity({in_ch.current_size, in_ch.high_water,
                                           in_ch.on_demand});
                plan_q.push_back(plan_want);
                if (in_ch.on_demand) n_on_demand++;
                else n_dense++;
                if (plan_want.policy_invalid) n_flagged++;
                if (plan_want.planned_size == SIZE_MAX) n_saturated++;
                send_gap = steady ? 0 : pick_gap();
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (req_q.size() != 0 &&
                             (!req_q[0].drain || plan_q.size() == 0)) begin
                    in_ch.valid        <= 1'b1;
                    in_ch.current_size <= req_q[0].req.current_size;
                    in_ch.high_water   <= req_q[0].req.high_water;
                    in_ch.on_demand    <= req_q[0].req.on_demand;
                    void'(req_q.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                plan_got = {out_ch.planned_size, out_ch.policy_invalid};
                if (plan_q.size() == 0) begin
                    $error("result with no request pending: planned_size %0h",
                           plan_got.planned_size);
                    errors++;
                end else begin
                    plan_want = plan_q.pop_front();
                    if (plan_got.planned_size !== plan_want.planned_size) begin
                        $error("planned_size expected %0h actual %0h",
                               plan_want.planned_size, plan_got.planned_size);
                        errors++;
                    end
                    if (plan_got.policy_invalid !== plan_want.policy_invalid) begin
                        $error("policy_invalid expected %0b actual %0b",
                               plan_want.policy_invalid, plan_got.policy_invalid);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_req(logic [63:0] cur, logic [63:0] hw, logic od,
                           logic drain = 1'b0);
        t_pending_req item;
        item.req   = {cur, hw, od};
        item.drain = drain;
        req_q.push_back(item);
        total_pushed++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_FLOOR_ON_DEMAND: floor_od_r    = data;
            CFG_FLOOR_DENSE:     floor_dense_r = data;
            CFG_CEILING_BYTES:   ceiling_r     = data;
            CFG_DENSE_STEP:      step_r        = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [63:0] fod, logic [63:0] fd,
                                logic [63:0] ceil_v, logic [63:0] step_v);
        write_reg(CFG_FLOOR_ON_DEMAND, fod);
        write_reg(CFG_FLOOR_DENSE, fd);
        write_reg(CFG_CEILING_BYTES, ceil_v);
        write_reg(CFG_DENSE_STEP, step_v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_phases++;
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || results_seen != total_pushed) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] cur;
        logic [63:0] hw;
        logic [63:0] ceil_v;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.current_size = '0;
        in_ch.high_water   = '0;
        in_ch.on_demand    = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_FLOOR_ON_DEMAND;
        cfg_data           = '0;
        floor_od_r         = '0;
        floor_dense_r      = '0;
        ceiling_r          = '0;
        step_r             = '0;
        steady             = 1'b0;
        errors             = 0;
        total_pushed       = 0;
        results_seen       = 0;
        n_on_demand        = 0;
        n_dense            = 0;
        n_flagged          = 0;
        n_saturated        = 0;
        n_phases           = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: zero ceiling, no growth.
        add_req('0, '0, 1'b1);
        add_req('0, '0, 1'b0);
        add_req(SIZE_MAX, SIZE_MAX, 1'b1);
        add_req(SIZE_MAX, SIZE_MAX, 1'b0);
        add_req(64'd5, 64'd100, 1'b1);
        wait_idle();

        // Open ceiling, zero step, zero floors: saturation and stalled growth.
        steady = 1'b1;
        apply_config('0, '0, SIZE_MAX, '0);
        add_req('0, 64'd1000, 1'b1);
        add_req(64'd1, SIZE_MAX, 1'b1);
        add_req(64'd5, 64'd1000, 1'b0);
        add_req(64'h8000_0000_0000_0000, SIZE_MAX, 1'b1);
        add_req(64'd3, 64'h4000_0000_0000_0000, 1'b1);
        wait_idle();
        steady = 1'b0;

        // Ceiling clamps and starts above the ceiling.
        apply_config(64'h10000, 64'h4000, 64'h100000, 64'h3000);
        add_req('0, 64'h50000, 1'b0);
        add_req(64'h200000, '0, 1'b0);
        add_req(64'h100000, SIZE_MAX, 1'b1, 1'b1);
        add_req(64'h1000, 64'h0F0000, 1'b1);
        add_req('0, SIZE_MAX, 1'b0);
        wait_idle();

        // Floor above the ceiling and a maximal dense step.
        apply_config(SIZE_MAX, 64'd1, 64'h8000, SIZE_MAX);
        add_req('0, '0, 1'b1);
        add_req('0, 64'd5, 1'b0);
        add_req(SIZE_MAX, SIZE_MAX, 1'b0);
        wait_idle();

        apply_config('0, 64'h9000, 64'h8000, 64'd7);
        add_req('0, 64'h7000, 1'b1);
        add_req(64'd100, 64'h7000, 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p % 4 == 1);
            case ($urandom_range(0, 5))
                0: ceil_v = SIZE_MAX;
                1: ceil_v = rnd64() >> $urandom_range(8, 40);
                default: ceil_v = pick_val();
            endcase
            apply_config(($urandom_range(0, 1) == 0) ? '0 : pick_val() >> $urandom_range(0, 63),
                         ($urandom_range(0, 1) == 0) ? '0 : pick_val() >> $urandom_range(0, 63),
                         ceil_v,
                         ($urandom_range(0, 2) == 0) ? pick_val() :
                                                       ceil_v >> $urandom_range(1, 40));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 7 && ceiling_r != 0) begin
                    cur = ceiling_r >> $urandom_range(1, 48);
                    hw  = ceiling_r >> $urandom_range(0, 30);
                end else begin
                    cur = pick_val();
                    hw  = pick_val();
                end
                add_req(cur, hw, 1'($urandom_range(0, 1)), $urandom_range(0, 99) == 0);
            end
            wait_idle();
        end

        if (plan_q.size() != 0) begin
            $error("%0d predicted results never arrived", plan_q.size());
            errors++;
        end
        $display("Covered %0d sizing transactions over %0d register settings:",
                 results_seen, n_phases);
        $display("%0d on-demand, %0d dense, %0d flagged, %0d saturated at the size maximum.",
                 n_on_demand, n_dense, n_flagged, n_saturated);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mcp_pkg.sv
rtl/mcp_in_if.sv
rtl/mcp_out_if.sv
rtl/mcp_datapath.sv
rtl/mcp_ctrl.sv
rtl/map_capacity_planner.sv
bench/map_capacity_planner_tb.sv
